### rtl/core/hash_table_age_depth_replace_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hash table replacement unit
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef HASH_TABLE_AGE_DEPTH_REPLACE_UNIT_MACROS_SVH
`define HASH_TABLE_AGE_DEPTH_REPLACE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define HTADR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hash table assertion failed");
// A condition that must never be true at a clock edge outside reset.
`define HTADR_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("hash table forbidden condition seen");
`else
`define HTADR_ASSERT(lbl, clk, rst_n, prop)
`define HTADR_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### rtl/core/htadr_pkg.sv
// ----------------------------------------------------------------------------
// Hash table replacement package
// Sizes, entry layout and shared types of the hash table unit.
// ----------------------------------------------------------------------------
package htadr_pkg;

	// The bucket count is a power of two, so the bucket is the low hash bits.
	localparam int BUCKET_COUNT = 1024;
	localparam int WAYS         = 3;
	localparam int BUCKET_BITS  = $clog2(BUCKET_COUNT);
	localparam int WAY_BITS     = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam int HASH_W  = 64;
	localparam int LOCK_W  = 32;
	localparam int MOVE_W  = 16;
	localparam int DEPTH_W = 8;
	localparam int AGE_W   = 6;
	localparam int BOUND_W = 2;
	localparam int ENTRY_W = LOCK_W + MOVE_W + DEPTH_W + AGE_W + BOUND_W;
	localparam int ROW_W   = WAYS * ENTRY_W;

	localparam int SCORE_SHIFT = 8;
	localparam int SCORE_W     = AGE_W + SCORE_SHIFT + 2;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 6;

	localparam logic [BOUND_W-1:0] EXACT_BOUND_RESET = 2'd3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CURRENT_AGE = 1'b0,
		CFG_EXACT_BOUND = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_STORE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

	typedef struct packed {
		logic [LOCK_W-1:0]         lock;
		logic [MOVE_W-1:0]         move;
		logic signed [DEPTH_W-1:0] depth;
		logic [AGE_W-1:0]          age;
		logic [BOUND_W-1:0]        bound;
	} entry_t;

	typedef entry_t [WAYS-1:0] row_t;

	typedef struct packed {
		logic                      wr_en;
		row_t                      wr_row;
		logic                      hit;
		logic [MOVE_W-1:0]         move;
		logic signed [DEPTH_W-1:0] depth;
		logic [BOUND_W-1:0]        bound;
		logic [AGE_W-1:0]          age;
	} decision_t;

endpackage

### rtl/core/htadr_ram.sv
// ----------------------------------------------------------------------------
// Hash table bucket memory
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module htadr_ram #(
	parameter int DATA_W = 64,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### rtl/core/htadr_pick.sv
// ----------------------------------------------------------------------------
// Hash table way selection
// Matches the lock against a bucket, picks the way to refresh or replace and
// builds the updated bucket and the result fields.
// ----------------------------------------------------------------------------
module htadr_pick (
	input  htadr_pkg::row_t                      rd_row,
	input  htadr_pkg::op_t                       op,
	input  logic [htadr_pkg::LOCK_W-1:0]         lock,
	input  logic [htadr_pkg::MOVE_W-1:0]         move_in,
	input  logic signed [htadr_pkg::DEPTH_W-1:0] depth_in,
	input  logic [htadr_pkg::BOUND_W-1:0]        bound_in,
	input  logic [htadr_pkg::AGE_W-1:0]          current_age,
	input  logic [htadr_pkg::BOUND_W-1:0]        exact_bound_code,
	output htadr_pkg::decision_t                 dec
);
	import htadr_pkg::*;

	logic                      found;
	logic [WAY_BITS-1:0]       fway;
	logic [WAY_BITS-1:0]       victim;
	logic signed [SCORE_W-1:0] score [WAYS];
	logic signed [SCORE_W-1:0] best;
	logic [AGE_W-1:0]          age_dist [WAYS];
	entry_t                    fresh;
	logic                      overwrite;

	always_comb begin
		found = 1'b0;
		fway  = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && rd_row[w].lock == lock) begin
				found = 1'b1;
				fway  = WAY_BITS'(w);
			end
		end
	end

	// Score is the age distance times 256 minus the stored depth.
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			age_dist[w] = current_age - rd_row[w].age;
			score[w] = $signed({{(SCORE_W - AGE_W - SCORE_SHIFT){1'b0}}, age_dist[w],
				{SCORE_SHIFT{1'b0}}})
				- $signed({{(SCORE_W - DEPTH_W){rd_row[w].depth[DEPTH_W-1]}},
				rd_row[w].depth});
		end
	end

	always_comb begin
		best   = score[0];
		victim = '0;
		for (int w = 1; w < WAYS; w++) begin
			if (score[w] > best) begin
				best   = score[w];
				victim = WAY_BITS'(w);
			end
		end
	end

	assign fresh = '{lock: lock, move: move_in, depth: depth_in, age: current_age,
		bound: bound_in};
	assign overwrite = (bound_in == exact_bound_code) || (depth_in >= rd_row[fway].depth);

	always_comb begin
		dec        = '0;
		dec.wr_row = rd_row;
		if (op == OP_LOOKUP) begin
			if (found) begin
				dec.wr_en              = 1'b1;
				dec.wr_row[fway].age   = current_age;
				dec.hit                = 1'b1;
				dec.move               = rd_row[fway].move;
				dec.depth              = rd_row[fway].depth;
				dec.bound              = rd_row[fway].bound;
				dec.age                = current_age;
			end
		end else if (found) begin
			if (overwrite) begin
				dec.wr_en        = 1'b1;
				dec.wr_row[fway] = fresh;
				dec.hit          = 1'b1;
			end
		end else begin
			dec.wr_en          = 1'b1;
			dec.wr_row[victim] = fresh;
			dec.hit            = 1'b1;
		end
	end

endmodule

### rtl/core/hash_table_age_depth_replace_unit.sv
// ----------------------------------------------------------------------------
// Hash table unit with age and depth replacement
// One request at a time: read bucket, then write back and register result.
// The result is registered after the bucket read; the next request waits until it is loaded.
// After reset a clearing pass zeroes all 1024 buckets and takes no requests.
// ----------------------------------------------------------------------------
`include "hash_table_age_depth_replace_unit_macros.svh"

module hash_table_age_depth_replace_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [htadr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [htadr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic [htadr_pkg::HASH_W-1:0]         hash,
	input  logic [htadr_pkg::MOVE_W-1:0]         move_in,
	input  logic signed [htadr_pkg::DEPTH_W-1:0] depth_in,
	input  logic [htadr_pkg::BOUND_W-1:0]        bound_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hit,
	output logic [htadr_pkg::MOVE_W-1:0]         stored_move,
	output logic signed [htadr_pkg::DEPTH_W-1:0] stored_depth,
	output logic [htadr_pkg::BOUND_W-1:0]        stored_bound,
	output logic [htadr_pkg::AGE_W-1:0]          stored_age
);
	import htadr_pkg::*;

	state_t                    state_q;
	state_t                    state_next;
	logic [BUCKET_BITS-1:0]    clr_q;
	logic [AGE_W-1:0]          current_age_q;
	logic [BOUND_W-1:0]        exact_bound_q;

	op_t                       op_s1;
	logic [LOCK_W-1:0]         lock_s1;
	logic [BUCKET_BITS-1:0]    bucket_s1;
	logic [MOVE_W-1:0]         move_s1;
	logic signed [DEPTH_W-1:0] depth_s1;
	logic [BOUND_W-1:0]        bound_s1;

	logic                      out_valid_q;
	logic                      hit_q;
	logic [MOVE_W-1:0]         move_q;
	logic signed [DEPTH_W-1:0] depth_q;
	logic [BOUND_W-1:0]        bound_q;
	logic [AGE_W-1:0]          age_q;

	logic                      ram_we;
	logic                      ram_re;
	logic [BUCKET_BITS-1:0]    ram_addr;
	logic [ROW_W-1:0]          ram_wdata;
	logic [ROW_W-1:0]          ram_rdata;
	logic                      load_out;
	logic                      out_free;
	logic                      accept;
	decision_t                 dec;

	assign out_free = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	htadr_ram #(
		.DATA_W(ROW_W),
		.ADDR_W(BUCKET_BITS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	htadr_pick u_pick (
		.rd_row          (row_t'(ram_rdata)),
		.op              (op_s1),
		.lock            (lock_s1),
		.move_in         (move_s1),
		.depth_in        (depth_s1),
		.bound_in        (bound_s1),
		.current_age     (current_age_q),
		.exact_bound_code(exact_bound_q),
		.dec             (dec)
	);

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == BUCKET_BITS'(BUCKET_COUNT - 1)) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = bucket_s1;
		ram_wdata = dec.wr_row;
		load_out  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				ram_re   = in_valid;
				ram_addr = hash[BUCKET_BITS-1:0];
			end
			ST_LOOK: begin
				if (out_free) begin
					ram_we   = dec.wr_en;
					load_out = 1'b1;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_age_q <= '0;
			exact_bound_q <= EXACT_BOUND_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_CURRENT_AGE: current_age_q <= cfg_data[AGE_W-1:0];
				CFG_EXACT_BOUND: exact_bound_q <= cfg_data[BOUND_W-1:0];
				default: begin
					current_age_q <= current_age_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op_t'(op);
			lock_s1   <= hash[HASH_W-1 -: LOCK_W];
			bucket_s1 <= hash[BUCKET_BITS-1:0];
			move_s1   <= move_in;
			depth_s1  <= depth_in;
			bound_s1  <= bound_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hit_q   <= dec.hit;
			move_q  <= dec.move;
			depth_q <= dec.depth;
			bound_q <= dec.bound;
			age_q   <= dec.age;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign stored_move  = move_q;
	assign stored_depth = depth_q;
	assign stored_bound = bound_q;
	assign stored_age   = age_q;

	`HTADR_NEVER(a_no_request_while_clearing, clk, arst_n, state_q == ST_CLEAR && in_ready)
	`HTADR_ASSERT(a_accept_reads_bucket, clk, arst_n, accept |=> state_q == ST_LOOK)
	`HTADR_NEVER(a_no_result_overwrite, clk, arst_n, load_out && out_valid_q && !out_ready)
	`HTADR_NEVER(a_single_port_use, clk, arst_n, ram_we && ram_re)

endmodule

### tb/hash_table_age_depth_replace_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table replacement unit checker
// Watches the request and result channels and the register writes, keeps its
// own copy of the bucket table, and compares every result with its prediction.
// ----------------------------------------------------------------------------
module hash_table_age_depth_replace_unit_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [htadr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [htadr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic                                 op,
	input  logic [htadr_pkg::HASH_W-1:0]         hash,
	input  logic [htadr_pkg::MOVE_W-1:0]         move_in,
	input  logic signed [htadr_pkg::DEPTH_W-1:0] depth_in,
	input  logic [htadr_pkg::BOUND_W-1:0]        bound_in,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic                                 hit,
	input  logic [htadr_pkg::MOVE_W-1:0]         stored_move,
	input  logic signed [htadr_pkg::DEPTH_W-1:0] stored_depth,
	input  logic [htadr_pkg::BOUND_W-1:0]        stored_bound,
	input  logic [htadr_pkg::AGE_W-1:0]          stored_age,
	output int                                   outstanding,
	output int                                   mismatches
);
	import htadr_pkg::*;

	typedef struct packed {
		logic                      hit;
		logic [MOVE_W-1:0]         move;
		logic signed [DEPTH_W-1:0] depth;
		logic [BOUND_W-1:0]        bound;
		logic [AGE_W-1:0]          age;
	} answer_t;

	row_t               bucket_rows [BUCKET_COUNT];
	logic [AGE_W-1:0]   current_age;
	logic [BOUND_W-1:0] exact_bound;
	answer_t            expected_answers [$];

	function automatic answer_t table_access(input op_t kind, input logic [HASH_W-1:0] key,
			input logic [MOVE_W-1:0] mv, input logic signed [DEPTH_W-1:0] dp,
			input logic [BOUND_W-1:0] bd);
		logic [BUCKET_BITS-1:0] bucket;
		logic [LOCK_W-1:0]      lock;
		logic [AGE_W-1:0]       age_gap;
		row_t                   row;
		answer_t                answer;
		int                     w;
		int                     victim;
		int                     best_score;
		int                     score;
		bit                     found;
		bit                     keep_new;
		bucket = key[BUCKET_BITS-1:0];
		lock = key[HASH_W-1:HASH_W-LOCK_W];
		row = bucket_rows[bucket];
		answer = '0;
		found = 1'b0;
		if (kind == OP_LOOKUP) begin
			for (w = 0; w < WAYS; w++) begin
				if (!found && row[w].lock == lock) begin
					found = 1'b1;
					row[w].age = current_age;
					answer = '{1'b1, row[w].move, row[w].depth, row[w].bound, current_age};
				end
			end
		end else begin
			victim = 0;
			keep_new = 1'b1;
			best_score = -(1 << 30);
			for (w = 0; w < WAYS && !found; w++) begin
				if (row[w].lock == lock) begin
					found = 1'b1;
					if (bd == exact_bound || dp >= $signed(row[w].depth))
						victim = w;
					else
						keep_new = 1'b0;
				end else begin
					age_gap = current_age - row[w].age;
					score = int'(age_gap) * 256 - int'($signed(row[w].depth));
					if (score > best_score) begin
						best_score = score;
						victim = w;
					end
				end
			end
			if (keep_new) begin
				row[victim] = '{lock, mv, dp, current_age, bd};
				answer.hit = 1'b1;
			end
		end
		bucket_rows[bucket] = row;
		return answer;
	endfunction

	always @(posedge clk) begin
		answer_t seen;
		answer_t want;
		if (!arst_n) begin
			foreach (bucket_rows[b])
				bucket_rows[b] = '0;
			current_age = '0;
			exact_bound = EXACT_BOUND_RESET;
			expected_answers.delete();
			mismatches = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = '{hit, stored_move, stored_depth, stored_bound, stored_age};
				if (expected_answers.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual hit=%0b move=%h",
						$time, hit, stored_move);
				end else begin
					want = expected_answers.pop_front();
					if (seen !== want) begin
						mismatches++;
						$display("%0t: result mismatch, expected hit=%0b move=%h depth=%0d",
							$time, want.hit, want.move, want.depth,
							" bound=%0d age=%0d, actual hit=%0b move=%h depth=%0d",
							want.bound, want.age, seen.hit, seen.move, seen.depth,
							" bound=%0d age=%0d", seen.bound, seen.age);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_CURRENT_AGE: current_age = cfg_data[AGE_W-1:0];
					CFG_EXACT_BOUND: exact_bound = cfg_data[BOUND_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_answers.push_back(table_access(op_t'(op), hash, move_in, depth_in,
					bound_in));
		end
		outstanding = expected_answers.size();
	end

endmodule

### tb/hash_table_age_depth_replace_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table replacement unit test
// Directed lookups and stores on a few buckets, then random traffic aimed at
// a small set of buckets and locks under several register settings, with
// random idle cycles on both channels and a long result stall.
// ----------------------------------------------------------------------------
module hash_table_age_depth_replace_unit_test;
	import htadr_pkg::*;

	localparam int MID_W          = HASH_W - LOCK_W - BUCKET_BITS;
	localparam int POOL_SIZE      = 8;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_REQUESTS = 100;
	localparam int LONG_HOLD      = 60;
	localparam int STALL_LIMIT    = 4000;
	localparam int SETTLE_CYCLES  = 8;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      op = 1'b0;
	logic [HASH_W-1:0]         hash = '0;
	logic [MOVE_W-1:0]         move_in = '0;
	logic signed [DEPTH_W-1:0] depth_in = '0;
	logic [BOUND_W-1:0]        bound_in = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      hit;
	logic [MOVE_W-1:0]         stored_move;
	logic signed [DEPTH_W-1:0] stored_depth;
	logic [BOUND_W-1:0]        stored_bound;
	logic [AGE_W-1:0]          stored_age;
	int                        outstanding;
	int                        mismatches;

	bit                        hold_off = 1'b0;
	bit                        no_idle = 1'b0;
	logic [LOCK_W-1:0]         lock_pool [POOL_SIZE];
	logic [BUCKET_BITS-1:0]    bucket_pool [POOL_SIZE];

	hash_table_age_depth_replace_unit dut (.*);

	hash_table_age_depth_replace_unit_checker checker_inst (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [HASH_W-1:0] make_key(input logic [LOCK_W-1:0] lock,
			input logic [BUCKET_BITS-1:0] bucket);
		return {lock, MID_W'($urandom), bucket};
	endfunction

	task automatic send_request(input op_t kind, input logic [HASH_W-1:0] key,
			input logic [MOVE_W-1:0] mv, input logic signed [DEPTH_W-1:0] dp,
			input logic [BOUND_W-1:0] bd);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		op = kind;
		hash = key;
		move_in = mv;
		depth_in = dp;
		bound_in = bd;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic random_request();
		logic [HASH_W-1:0] key;
		if ($urandom_range(0, 9) == 0)
			key = {$urandom, $urandom};
		else
			key = make_key(lock_pool[$urandom_range(0, POOL_SIZE - 1)],
				bucket_pool[$urandom_range(0, POOL_SIZE - 1)]);
		send_request(op_t'($urandom_range(0, 1)), key, MOVE_W'($urandom),
			DEPTH_W'($urandom), BOUND_W'($urandom));
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int gap;
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 3);
			if (hold_off) begin
				hold_off = 1'b0;
				gap = LONG_HOLD;
			end
			@(negedge clk);
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("** hash_table_age_depth_replace_unit: FAILED **");
		$finish;
	end

	initial begin
		int phase;
		int n;
		logic [AGE_W-1:0] age_value;
		lock_pool[0] = '0;
		lock_pool[1] = '1;
		bucket_pool[0] = '0;
		bucket_pool[1] = '1;
		for (n = 2; n < POOL_SIZE; n++) begin
			lock_pool[n] = $urandom;
			bucket_pool[n] = BUCKET_BITS'($urandom);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Cleared entries have lock zero, so this lookup finds one.
		send_request(OP_LOOKUP, make_key(32'h0, 10'd0), 16'hFFFF, 8'h7F, 2'd3);
		send_request(OP_LOOKUP, make_key('1, 10'd0), 16'h0000, 8'h80, 2'd0);
		send_request(OP_STORE, make_key(32'h1234_5678, 10'd0), 16'hFFFF, 8'h7F, 2'd0);
		send_request(OP_LOOKUP, make_key(32'h1234_5678, 10'd0), 16'h0000, 8'h00, 2'd0);
		send_request(OP_STORE, make_key(32'h1234_5678, 10'd0), 16'h1111, 8'h80, 2'd1);
		send_request(OP_STORE, make_key(32'h1234_5678, 10'd0), 16'h2222, 8'h7F, 2'd2);
		send_request(OP_STORE, make_key(32'h1234_5678, 10'd0), 16'h3333, 8'h80, 2'd3);
		send_request(OP_LOOKUP, make_key(32'h1234_5678, 10'd0), 16'hFFFF, 8'h7F, 2'd3);
		send_request(OP_LOOKUP, make_key(32'h0, 10'd0), 16'h0000, 8'h00, 2'd1);
		send_request(OP_STORE, make_key(32'h0, 10'd0), 16'h4444, 8'hFF, 2'd1);
		send_request(OP_STORE, make_key(32'h0, 10'd0), 16'h5555, 8'h00, 2'd0);
		send_request(OP_STORE, make_key('1, '1), 16'h0000, 8'h80, 2'd0);
		send_request(OP_STORE, make_key(32'h0000_0001, '1), 16'h0001, 8'h00, 2'd1);
		send_request(OP_STORE, make_key(32'h8000_0000, '1), 16'h8000, 8'h7F, 2'd2);
		send_request(OP_STORE, make_key(32'h7FFF_FFFF, '1), 16'h7FFF, 8'h40, 2'd3);
		send_request(OP_LOOKUP, make_key('1, '1), 16'h0000, 8'h00, 2'd0);
		send_request(OP_LOOKUP, make_key(32'h0000_0001, '1), 16'h0000, 8'h00, 2'd0);
		send_request(OP_LOOKUP, make_key(32'h8000_0000, '1), 16'h0000, 8'h00, 2'd0);
		send_request(OP_LOOKUP, make_key(32'h7FFF_FFFF, '1), 16'h0000, 8'h00, 2'd0);
		send_request(OP_STORE, '1, 16'hFFFF, 8'hFF, 2'd3);
		send_request(OP_LOOKUP, '1, 16'hFFFF, 8'hFF, 2'd3);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_until_drained();
			case (phase)
				0: age_value = '1;
				1: age_value = '0;
				2: age_value = 6'd1;
				default: age_value = AGE_W'($urandom);
			endcase
			write_register(CFG_CURRENT_AGE, age_value);
			write_register(CFG_EXACT_BOUND, {4'($urandom), 2'(phase)});
			no_idle = (phase % 3 == 1);
			for (n = 0; n < PHASE_REQUESTS; n++) begin
				if (phase == 2 && n == 20)
					hold_off = 1'b1;
				if (phase == 3 && n == 50)
					wait_until_drained();
				random_request();
			end
		end
		wait_until_drained();

		if (mismatches == 0)
			$display("** hash_table_age_depth_replace_unit: PASSED **");
		else
			$display("** hash_table_age_depth_replace_unit: FAILED **");
		$finish;
	end

endmodule
